// ----- src/sil_pkg.sv -----
// shared constants, codes and types of the sorted insert list
package sil_pkg;

	localparam int CAPACITY    = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int POS_W       = 4;
	localparam int VAL_W       = 8;
	localparam int ADDR_W      = 3;

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_ASC    = 2'd1;
	localparam logic [1:0] MODE_DESC   = 2'd2;

	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_DUMP    = 1'b1;
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_ELEM   = 1'b1;

	localparam logic REG_ORDER_MODE = 1'b0;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic       insert;
		logic       dump_shift;
		logic [1:0] mode;
		val_t       value;
	} sil_ctl_t;

endpackage

// ----- src/sil_cell.sv -----
// one list cell: holds an entry, compares against the new value and shifts
module sil_cell import sil_pkg::*; (
	input  logic     clk,
	input  sil_ctl_t ctl,
	input  logic     occupied,
	input  logic     is_tail,
	input  logic     pass_in,
	input  val_t     left_val,
	input  val_t     right_val,
	input  val_t     wrap_val,
	output logic     pass_out,
	output logic     ins_here,
	output val_t     val_out
);

	val_t entry_q;
	logic beyond;
	logic go_on;

	always_comb begin
		case (ctl.mode)
			MODE_ASC:  beyond = ctl.value > entry_q;
			MODE_DESC: beyond = ctl.value < entry_q;
			default:   beyond = 1'b1;
		endcase
		go_on    = occupied & beyond;
		pass_out = pass_in & go_on;
		ins_here = pass_in & ~go_on;
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (ins_here)
				entry_q <= ctl.value;
			else if (!pass_in)
				entry_q <= left_val;
		end else if (ctl.dump_shift) begin
			// rotate toward the head; the tail wraps the head back in
			entry_q <= is_tail ? wrap_val : right_val;
		end
	end

	assign val_out = entry_q;

endmodule

// ----- src/sorted_insert_list.sv -----
// sorted insert list top: cell chain, request sequencing, apb register
// insert: accepted when idle and the output register is free; result next cycle
// dump of n entries: the chain rotates one place per cycle past cell 0 while the output register is free
// throughput: one insert per cycle while the output register is free; a dump blocks new requests until it completes
// empty dump and full insert give one result
// reset clears state, fill count, dump counter, order mode and output valid; entries are not cleared
module sorted_insert_list import sil_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,  // [7:0] value
	input  logic              s_tuser,  // [0] command
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,  // [0] ok, [8:1] element, [12:9] position, zero pad
	output logic              m_tuser,  // [0] kind
	output logic              m_tlast,  // last
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       mode_q;

	logic             out_valid_q;
	logic             out_kind_q;
	logic             out_ok_q;
	val_t             out_elem_q;
	logic [POS_W-1:0] out_pos_q;
	logic             out_last_q;

	sil_ctl_t         ctl;
	logic [CAPACITY:0] pass;
	logic [CAPACITY-1:0] ins;
	val_t             vals [CAPACITY];
	logic [IDX_W-1:0] ins_idx;

	logic             slot_free;
	logic             accept;
	logic             full;
	logic             emit;
	logic             step;
	logic             out_load;
	logic [CNT_W-1:0] lim;

	// apb register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ORDER_MODE) ? {30'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_APPEND;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ORDER_MODE) begin
			mode_q <= pwdata[1:0];
		end
	end

	// handshake and sequencing
	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && slot_free;
	assign accept    = s_tvalid && s_tready;
	assign full      = fill_q == CNT_W'(CAPACITY);

	always_comb begin
		if (32'(fill_q) > 32'(MAX_RESULTS))
			lim = CNT_W'(MAX_RESULTS);
		else
			lim = fill_q;
	end

	// entries past the result limit still rotate so the list comes back intact
	assign emit = cnt_q < lim;
	assign step = (state_q == ST_DUMP) && (!emit || slot_free);

	// a result is loaded for every insert, an empty dump and each emitted dump entry
	assign out_load = (accept && (s_tuser == CMD_INSERT || fill_q == '0)) || (step && emit);

	assign ctl.insert     = accept && s_tuser == CMD_INSERT && !full;
	assign ctl.dump_shift = step;
	assign ctl.mode       = mode_q;
	assign ctl.value      = val_t'(s_tdata);

	// cell chain
	assign pass[0] = 1'b1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sil_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occupied (fill_q > CNT_W'(i)),
			.is_tail  (fill_q == CNT_W'(i + 1)),
			.pass_in  (pass[i]),
			.left_val ((i == 0) ? ctl.value : vals[(i == 0) ? 0 : i - 1]),
			.right_val((i == CAPACITY - 1) ? vals[0] : vals[(i == CAPACITY - 1) ? 0 : i + 1]),
			.wrap_val (vals[0]),
			.pass_out (pass[i + 1]),
			.ins_here (ins[i]),
			.val_out  (vals[i])
		);
	end

	always_comb begin
		ins_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (ins[i])
				ins_idx = ins_idx | IDX_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == CMD_INSERT) begin
							if (!full)
								fill_q <= fill_q + CNT_W'(1);
						end else if (fill_q != '0) begin
							state_q <= ST_DUMP;
							cnt_q   <= '0;
						end
					end
				end
				ST_DUMP: begin
					if (step) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (cnt_q == fill_q - CNT_W'(1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (s_tuser == CMD_INSERT) begin
				out_kind_q <= KIND_STATUS;
				out_ok_q   <= !full;
				out_elem_q <= '0;
				out_pos_q  <= full ? '0 : POS_W'(ins_idx);
				out_last_q <= 1'b1;
			end else begin
				// dump request; only an empty dump loads this as a result
				out_kind_q <= KIND_ELEM;
				out_ok_q   <= 1'b0;
				out_elem_q <= '0;
				out_pos_q  <= '0;
				out_last_q <= 1'b1;
			end
		end else if (step && emit) begin
			out_kind_q <= KIND_ELEM;
			out_ok_q   <= 1'b1;
			out_elem_q <= vals[0];
			out_pos_q  <= POS_W'(cnt_q);
			out_last_q <= cnt_q == lim - CNT_W'(1);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_pos_q, out_elem_q, out_ok_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- tb/tb_sorted_insert_list.sv -----
// self-checking stream testbench for the sorted insert list with order mode phases
module tb_sorted_insert_list;
	import sil_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [ADDR_W-1:0] ORDER_MODE_ADDR = ADDR_W'(4 * REG_ORDER_MODE);
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;
	localparam int RAND_PER_PHASE = 53;

	typedef struct packed {
		logic cmd;
		val_t value;
	} request_t;

	typedef struct packed {
		logic             kind;
		logic             ok;
		val_t             element;
		logic [POS_W-1:0] position;
		logic             last;
	} list_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;   // [7:0] value
	logic              s_tuser = 1'b0; // [0] command
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;        // [0] ok, [8:1] element, [12:9] position, zero pad
	logic              m_tuser;        // [0] kind
	logic              m_tlast;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	request_t     req_q[$];
	list_result_t list_results_q[$];

	// shadow copy of the list
	val_t        list_slots[CAPACITY];
	int unsigned list_fill = 0;
	logic [1:0]  order_mode_shadow = MODE_APPEND;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	int unsigned hold_left = 0;
	bit          hold_go = 1'b0;
	bit          hold_done = 1'b0;

	sorted_insert_list dut (.*);

	always #5 clk = ~clk;

	function automatic void predict_list_results(input logic cmd, input val_t value);
		int unsigned pos;
		int unsigned n;
		if (cmd == CMD_INSERT) begin
			if (list_fill >= CAPACITY) begin
				list_results_q.push_back('{KIND_STATUS, 1'b0, '0, '0, 1'b1});
				return;
			end
			pos = list_fill;
			if (order_mode_shadow == MODE_ASC || order_mode_shadow == MODE_DESC) begin
				pos = 0;
				while (pos < list_fill && ((order_mode_shadow == MODE_ASC) ?
						(value > list_slots[pos]) : (value < list_slots[pos])))
					pos++;
				for (int unsigned i = list_fill; i > pos; i--)
					list_slots[i] = list_slots[i - 1];
			end
			list_slots[pos] = value;
			list_fill++;
			list_results_q.push_back('{KIND_STATUS, 1'b1, '0, POS_W'(pos), 1'b1});
		end else begin
			if (list_fill == 0) begin
				list_results_q.push_back('{KIND_ELEM, 1'b0, '0, '0, 1'b1});
				return;
			end
			n = (list_fill > MAX_RESULTS) ? MAX_RESULTS : list_fill;
			for (int unsigned i = 0; i < n; i++)
				list_results_q.push_back('{KIND_ELEM, 1'b1, list_slots[i], POS_W'(i),
					(i + 1 == n)});
		end
	endfunction

	// request driver
	always @(posedge clk) begin : drive
		request_t nxt;
		if (s_tvalid && s_tready)
			predict_list_results(s_tuser, val_t'(s_tdata));
		if (!s_tvalid || s_tready) begin
			if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = req_q.pop_front();
				s_tuser <= nxt.cmd;
				s_tdata <= nxt.value;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver ready, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
			if (hold_left == 1)
				hold_done <= 1'b1;
		end else if (hold_go && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin : monitor
		list_result_t got;
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[0], val_t'(m_tdata[8:1]), m_tdata[12:9], m_tlast};
			if (list_results_q.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result kind=%0d ok=%0d element=%0d position=%0d last=%0d",
					$realtime, got.kind, got.ok, got.element, got.position, got.last);
			end else begin
				want = list_results_q.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t mismatch expected kind=%0d ok=%0d element=%0d position=%0d last=%0d",
						$realtime, want.kind, want.ok, want.element, want.position, want.last);
					$display("%0t          actual   kind=%0d ok=%0d element=%0d position=%0d last=%0d",
						$realtime, got.kind, got.ok, got.element, got.position, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_req(input logic cmd, input int value);
		req_q.push_back('{cmd, val_t'(value)});
	endtask

	task automatic set_order_mode(input logic [1:0] mode);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ORDER_MODE_ADDR;
		pwdata <= 32'(mode);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		order_mode_shadow = mode;
	endtask

	task automatic drain();
		while (req_q.size() != 0 || s_tvalid || list_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [1:0] phase_mode[4];
		int unsigned phase_send[4];
		int unsigned phase_recv[4];
		phase_mode = '{MODE_ASC, MODE_DESC, MODE_SPARE, MODE_APPEND};
		phase_send = '{0, 83, 0, 27};
		phase_recv = '{0, 0, 83, 27};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list dump, then sorted inserts with extremes and equal values
		queue_req(CMD_DUMP, 0);
		drain();
		set_order_mode(MODE_ASC);
		queue_req(CMD_INSERT, 0);
		queue_req(CMD_INSERT, 127);
		queue_req(CMD_INSERT, -128);
		queue_req(CMD_INSERT, -1);
		queue_req(CMD_INSERT, 0);
		queue_req(CMD_DUMP, 0);
		drain();
		set_order_mode(MODE_DESC);
		queue_req(CMD_INSERT, 1);
		queue_req(CMD_INSERT, -128);
		queue_req(CMD_INSERT, 127);
		queue_req(CMD_INSERT, 1);
		queue_req(CMD_DUMP, 0);
		drain();
		// unused mode code appends
		set_order_mode(MODE_SPARE);
		queue_req(CMD_INSERT, -7);
		queue_req(CMD_DUMP, 0);
		drain();
		set_order_mode(MODE_APPEND);
		queue_req(CMD_INSERT, 127);
		queue_req(CMD_INSERT, -128);
		queue_req(CMD_DUMP, 0);
		drain();

		// random phases; the list fills early in the first and refuses inserts after that
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_send[p];
			recv_stall_pct = phase_recv[p];
			set_order_mode(phase_mode[p]);
			for (int i = 0; i < RAND_PER_PHASE; i++)
				queue_req(($urandom_range(99) < 60) ? CMD_INSERT : CMD_DUMP,
					$urandom_range(255));
			if (p == 0)
				hold_go = 1'b1;
			drain();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0 && list_results_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
